@@ src/fanout_response_tracker_defines.svh @@
// assertion macros for the fan-out response tracker
`ifndef FANOUT_RESPONSE_TRACKER_DEFINES_SVH
`define FANOUT_RESPONSE_TRACKER_DEFINES_SVH

`ifndef SYNTH
`define FRT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FRT_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRT_ASSERT(lbl, clk, rstn, prop, msg)
`define FRT_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

@@ src/frt_pkg.sv @@
// shared types for the fan-out response tracker
package frt_pkg;

  localparam int unsigned SessionW = 64;
  localparam int unsigned CountW   = 4;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NO_MATCH
  } frt_status_e;

  typedef struct packed {
    logic [CountW-1:0]   pending;
    logic [SessionW-1:0] session;
  } frt_entry_t;

  typedef struct packed {
    frt_status_e       status;
    logic              broadcast;
    logic              forward;
    logic [CountW-1:0] entry_index;
    logic [CountW-1:0] remaining;
  } frt_result_t;

endpackage

@@ src/fanout_response_tracker.sv @@
// request: scans upward from entry zero for the lowest free entry; full if none is free
// response: scans the entries for the session, reading then comparing each valid one;
// free entries are skipped, and no match is reported if no valid entry holds the session
// one beat in flight at a time; the next beat is taken only once the result has reached
// the output register
// reset clears the valid bits and sets fanout_count to 1; the session store is not cleared
module fanout_response_tracker import frt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // session
  input  logic [1:0]  s_axis_tuser,  // mode, crash_teardown
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // broadcast_to_nodes, forward_to_front, entry_index,
                                     // remaining, zero fill
  output logic [1:0]  m_axis_tuser   // status
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [CountW-1:0] fanout_q;
  frt_result_t       res;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  frt_entry_t        ram_wdata;
  frt_entry_t        ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fanout_q <= CountW'(1);
    end else if (cfg_we_i) begin
      fanout_q <= cfg_wdata_i;
    end
  end

  frt_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fanout_i    (fanout_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser[0]),
    .in_crash_i  (s_axis_tuser[1]),
    .in_session_i(s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  frt_ram #(
    .WIDTH($bits(frt_entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tdata = {6'b0, res.remaining, res.entry_index, res.forward, res.broadcast};
  assign m_axis_tuser = res.status;

endmodule

@@ src/frt_ram.sv @@
// generic single-write single-read ram with registered read
module frt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/frt_ctrl.sv @@
// scan sequencer, valid bits and result register of the tracker
`include "fanout_response_tracker_defines.svh"

module frt_ctrl import frt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int unsigned CNT_W = IDX_W + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CountW-1:0] fanout_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_mode_i,
  input  logic              in_crash_i,
  input  logic [SessionW-1:0] in_session_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output frt_result_t       out_res_o,
  output logic              ram_we_o,
  output logic [IDX_W-1:0]  ram_waddr_o,
  output frt_entry_t        ram_wdata_o,
  output logic [IDX_W-1:0]  ram_raddr_o,
  input  frt_entry_t        ram_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REQ,
    S_RSP_RD,
    S_RSP_CMP,
    S_EMIT
  } state_e;

  state_e                     state_q;
  logic [CNT_W-1:0]           scan_q;
  logic                       mode_q;
  logic                       crash_q;
  logic [SessionW-1:0]        sid_q;
  logic [TABLE_ENTRIES-1:0]   valid_q;
  frt_result_t                res_q;
  frt_result_t                out_q;
  logic                       out_valid_q;

  logic [IDX_W-1:0]           idx;
  logic [IDX_W+CountW-1:0]    idx_ext;
  logic [CountW-1:0]          idx4;
  logic                       scan_end;
  logic                       hit;
  logic                       last;
  logic [CountW-1:0]          pend_dec;
  logic                       out_free;

  function automatic frt_result_t make_res(frt_status_e st, logic bc, logic fw,
                                           logic [CountW-1:0] ei,
                                           logic [CountW-1:0] rem);
    frt_result_t r;
    r.status      = st;
    r.broadcast   = bc;
    r.forward     = fw;
    r.entry_index = ei;
    r.remaining   = rem;
    return r;
  endfunction

  assign idx      = scan_q[IDX_W-1:0];
  assign idx_ext  = {{CountW{1'b0}}, idx};
  assign idx4     = idx_ext[CountW-1:0];
  assign scan_end = (scan_q == CNT_W'(TABLE_ENTRIES));
  assign hit      = (ram_rdata_i.session == sid_q);
  assign last     = (ram_rdata_i.pending <= CountW'(1));
  assign pend_dec = ram_rdata_i.pending - CountW'(1);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = idx;
    ram_raddr_o = idx;
    ram_wdata_o.pending = pend_dec;
    ram_wdata_o.session = ram_rdata_i.session;
    if (state_q == S_REQ) begin
      ram_we_o = !scan_end && !valid_q[idx] && !crash_q;
      ram_wdata_o.pending = fanout_i;
      ram_wdata_o.session = sid_q;
    end else if (state_q == S_RSP_CMP) begin
      ram_we_o = hit && !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      mode_q      <= 1'b0;
      crash_q     <= 1'b0;
      sid_q       <= '0;
      valid_q     <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= in_mode_i;
            crash_q <= in_crash_i;
            sid_q   <= in_session_i;
            scan_q  <= '0;
            state_q <= in_mode_i ? S_RSP_RD : S_REQ;
          end
        end
        S_REQ: begin
          if (scan_end) begin
            res_q   <= make_res(ST_FULL, 1'b0, 1'b0, '0, '0);
            state_q <= S_EMIT;
          end else if (!valid_q[idx]) begin
            if (crash_q) begin
              res_q <= make_res(ST_OK, 1'b1, 1'b0, '0, '0);
            end else begin
              valid_q[idx] <= 1'b1;
              res_q <= make_res(ST_OK, 1'b1, 1'b0, idx4, fanout_i);
            end
            state_q <= S_EMIT;
          end else begin
            scan_q <= scan_q + CNT_W'(1);
          end
        end
        S_RSP_RD: begin
          if (scan_end) begin
            res_q   <= make_res(ST_NO_MATCH, 1'b0, 1'b0, '0, '0);
            state_q <= S_EMIT;
          end else if (valid_q[idx]) begin
            state_q <= S_RSP_CMP;
          end else begin
            scan_q <= scan_q + CNT_W'(1);
          end
        end
        S_RSP_CMP: begin
          if (hit) begin
            if (last) begin
              valid_q[idx] <= 1'b0;
              res_q <= make_res(ST_OK, 1'b0, 1'b1, idx4, '0);
            end else begin
              res_q <= make_res(ST_OK, 1'b0, 1'b0, idx4, pend_dec);
            end
            state_q <= S_EMIT;
          end else begin
            scan_q  <= scan_q + CNT_W'(1);
            state_q <= S_RSP_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = rst_ni && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `FRT_ASSERT(a_err_fields_zero, clk_i, rst_ni,
    out_valid_q && (out_q.status != ST_OK) |-> (out_q.entry_index == '0) &&
    (out_q.remaining == '0) && !out_q.broadcast && !out_q.forward,
    "error beat carries non-zero fields")
  `FRT_ASSERT(a_ram_we_in_scan, clk_i, rst_ni,
    ram_we_o |-> (state_q == S_REQ) || (state_q == S_RSP_CMP),
    "table write outside a scan step")
  `FRT_ASSERT(a_cmp_on_valid, clk_i, rst_ni,
    (state_q == S_RSP_CMP) |-> valid_q[idx] && mode_q, "compare on a free entry")
  `FRT_ASSERT(a_scan_start, clk_i, rst_ni,
    in_valid_i && in_ready_o |=> (scan_q == '0), "scan does not restart at entry zero")
  `FRT_ASSERT_NORST(a_scan_bound, clk_i,
    scan_q <= CNT_W'(TABLE_ENTRIES), "scan index past the table")

endmodule
